// ----- hdl/jdd_pkg.sv -----
// Package for the joystick dead zone / direction block.
// Command and status structs, operand, capture and register codes, CORDIC angle table.
// No dependencies.
package jdd_pkg;

    localparam int STEP_W = 5;                       // CORDIC table index width
    localparam logic [31:0] KINV_Q30 = 32'd652032874;
    localparam logic [19:0] MAG_MAX  = 20'd741456;

    // multiplier operand select
    localparam logic [3:0] MS_NONE = 4'd0;
    localparam logic [3:0] MS_CK   = 4'd1;
    localparam logic [3:0] MS_AA   = 4'd2;
    localparam logic [3:0] MS_YY   = 4'd3;
    localparam logic [3:0] MS_BB   = 4'd4;
    localparam logic [3:0] MS_XX   = 4'd5;
    localparam logic [3:0] MS_T    = 4'd6;
    localparam logic [3:0] MS_AB   = 4'd7;
    localparam logic [3:0] MS_RM   = 4'd8;
    localparam logic [3:0] MS_PX   = 4'd9;
    localparam logic [3:0] MS_PY   = 4'd10;

    // product capture destination
    localparam logic [2:0] CP_NONE = 3'd0;
    localparam logic [2:0] CP_TA   = 3'd1;
    localparam logic [2:0] CP_TB   = 3'd2;
    localparam logic [2:0] CP_Q    = 3'd3;
    localparam logic [2:0] CP_QADD = 3'd4;
    localparam logic [2:0] CP_AB   = 3'd5;

    // divider operand select
    localparam logic [1:0] DS_RAD = 2'd0;
    localparam logic [1:0] DS_PRJ = 2'd1;

    // configuration register indexes
    localparam logic [1:0] REG_RECT   = 2'd0;
    localparam logic [1:0] REG_DEAD_X = 2'd1;
    localparam logic [1:0] REG_DEAD_Y = 2'd2;

    typedef struct packed {
        logic              load;
        logic              cor_en;
        logic [STEP_W-1:0] step;
        logic [3:0]        mul_sel;
        logic [2:0]        cap_sel;
        logic              sqrt_start;
        logic              div_start;
        logic [1:0]        div_sel;
        logic              cap_mag;
        logic              cap_dir;
        logic              cap_net;
        logic              cap_xo;
        logic              cap_yo;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic nz;
        logic rect;
        logic sqrt_busy;
        logic div_busy;
    } t_stat;

    // atan(2^-i) as binary angle, 2^31 = pi
    function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/joystick_deadzone_direction.sv -----
// Top level of the joystick dead zone / direction block.
// Joins jdd_ctrl and jdd_dp; uses jdd_pkg.
//
//  channel | dir | handshake              | payload
//  s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata: x_raw, y_raw
//  m       | out | o_m_tvalid/i_m_tready  | o_m_tdata: x_out..angle
//  cfg     | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// Elliptical nonzero item: CORDIC, then the bit-serial square root and three
// 52-step divides after the multiplies; rectangular or zero sample: CORDIC
// and the magnitude multiply only, no root or divide.
// One item in flight at a time.
// Synchronous active-low reset clears config, held angle/direction, control.
// A result waits in the output register; the next item is taken meanwhile and
// stalls only at its end if the previous result is still not taken.
module joystick_deadzone_direction #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // x_raw[15:0], y_raw[31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // x_out[15:0], y_out[31:16], direction[35:32],
                                     // raw_magnitude[55:36], net_force[75:56],
                                     // angle[91:76], zero[95:92]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);
    jdd_pkg::t_cmd  w_cmd;
    jdd_pkg::t_stat w_stat;

    jdd_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    jdd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .o_m_tdata  (o_m_tdata)
    );
endmodule

// ----- hdl/jdd_sqrt.sv -----
// Iterative 64-bit integer square root, one result bit per cycle.
// Uses nothing outside this file.
module jdd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_v,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_v, r_res, r_bit;
    logic [63:0] w_sum;

    assign w_sum  = r_res + r_bit;
    assign o_busy = (r_bit != 64'd0);
    assign o_root = r_res[31:0];

    // bit walks down two places a step; 32 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 64'd0;
        end else if (i_start) begin
            r_bit <= 64'd1 << 62;
        end else if (o_busy) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_v;
            r_res <= 64'd0;
        end else if (o_busy) begin
            if (r_v >= w_sum) begin
                r_v   <= r_v - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end
endmodule

// ----- hdl/jdd_div.sv -----
// Restoring divider, 52-bit dividend by 32-bit divisor, one bit per cycle.
// Divide by zero returns zero. Uses nothing outside this file.
module jdd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [51:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [51:0] o_quot
);
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_dvs;
    logic [51:0] r_quo;
    logic        r_zero;
    logic [32:0] w_t;
    logic        w_ge;

    assign w_t    = {r_rem, r_quo[51]};
    assign w_ge   = (w_t >= {1'b0, r_dvs});
    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_zero ? 52'd0 : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd52;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // shift one dividend bit in, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= 32'd0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
            r_zero <= (i_divisor == 32'd0);
        end else if (o_busy) begin
            r_rem <= w_ge ? 32'(w_t - {1'b0, r_dvs}) : w_t[31:0];
            r_quo <= {r_quo[50:0], w_ge};
        end
    end
endmodule

// ----- hdl/jdd_dp.sv -----
// Datapath: config registers, CORDIC, shared multiplier, sqrt and divider,
// held angle/direction and the output register. Uses jdd_pkg, jdd_sqrt, jdd_div.
module jdd_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jdd_pkg::t_cmd  i_cmd,
    output jdd_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [14:0]    i_cfg_data,
    input  logic [31:0]    i_s_tdata,
    output logic [95:0]    o_m_tdata
);
    // configuration
    logic        r_rect;
    logic [14:0] r_dead_x, r_dead_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect   <= 1'b0;
            r_dead_x <= 15'd0;
            r_dead_y <= 15'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jdd_pkg::REG_RECT:   r_rect   <= i_cfg_data[0];
                jdd_pkg::REG_DEAD_X: r_dead_x <= i_cfg_data;
                jdd_pkg::REG_DEAD_Y: r_dead_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample and derived operands
    logic signed [15:0] r_x, r_y;
    logic [15:0]        r_ax, r_ay;
    logic [14:0]        r_a, r_b;
    logic               r_nz;
    logic signed [31:0] r_cx, r_cy;
    logic [31:0]        r_z;
    logic [63:0]        r_p;
    logic [31:0]        r_ta, r_tb;
    logic [63:0]        r_q;
    logic [29:0]        r_ab;
    logic [19:0]        r_mag, r_net;
    logic signed [15:0] r_xo, r_yo;
    logic [15:0]        r_hangle;
    logic [3:0]         r_hdir;

    logic signed [15:0] w_x, w_y;
    logic signed [31:0] w_x32, w_y32;
    assign w_x   = i_s_tdata[15:0];
    assign w_y   = i_s_tdata[31:16];
    assign w_x32 = 32'(w_x) <<< 12;
    assign w_y32 = 32'(w_y) <<< 12;

    // CORDIC step
    logic signed [31:0] w_shx, w_shy;
    logic [31:0]        w_atan;
    assign w_shx  = r_cx >>> i_cmd.step;
    assign w_shy  = r_cy >>> i_cmd.step;
    assign w_atan = jdd_pkg::atan_at(i_cmd.step);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= w_x;
            r_y  <= w_y;
            r_ax <= w_x[15] ? 16'(-w_x) : 16'(w_x);
            r_ay <= w_y[15] ? 16'(-w_y) : 16'(w_y);
            r_a  <= (r_dead_x == 15'd0) ? 15'd1 : r_dead_x;
            r_b  <= (r_dead_y == 15'd0) ? 15'd1 : r_dead_y;
            r_nz <= (w_x != 16'sd0) || (w_y != 16'sd0);
            if (w_x[15]) begin
                r_cx <= -w_x32;
                r_cy <= -w_y32;
                r_z  <= 32'h8000_0000;
            end else begin
                r_cx <= w_x32;
                r_cy <= w_y32;
                r_z  <= 32'd0;
            end
        end else if (i_cmd.cor_en) begin
            if (!r_cy[31]) begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_z  <= r_z + w_atan;
            end else begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_z  <= r_z - w_atan;
            end
        end
    end

    // shared multiplier, product registered
    logic [31:0] w_opa, w_opb;
    always_comb begin
        case (i_cmd.mul_sel)
            jdd_pkg::MS_CK: begin w_opa = r_cx;         w_opb = jdd_pkg::KINV_Q30; end
            jdd_pkg::MS_AA: begin w_opa = 32'(r_a);     w_opb = 32'(r_a);  end
            jdd_pkg::MS_YY: begin w_opa = 32'(r_ay);    w_opb = 32'(r_ay); end
            jdd_pkg::MS_BB: begin w_opa = 32'(r_b);     w_opb = 32'(r_b);  end
            jdd_pkg::MS_XX: begin w_opa = 32'(r_ax);    w_opb = 32'(r_ax); end
            jdd_pkg::MS_T:  begin w_opa = r_ta;         w_opb = r_tb;      end
            jdd_pkg::MS_AB: begin w_opa = 32'(r_a);     w_opb = 32'(r_b);  end
            jdd_pkg::MS_RM: begin w_opa = {1'b0, r_ab, 1'b0}; w_opb = 32'(r_mag); end
            jdd_pkg::MS_PX: begin w_opa = 32'(r_ax);    w_opb = 32'(r_net); end
            jdd_pkg::MS_PY: begin w_opa = 32'(r_ay);    w_opb = 32'(r_net); end
            default:        begin w_opa = 32'd0;        w_opb = 32'd0;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_opa * w_opb;
        case (i_cmd.cap_sel)
            jdd_pkg::CP_TA:   r_ta <= r_p[31:0];
            jdd_pkg::CP_TB:   r_tb <= r_p[31:0];
            jdd_pkg::CP_Q:    r_q  <= r_p;
            jdd_pkg::CP_QADD: r_q  <= r_q + r_p;
            jdd_pkg::CP_AB:   r_ab <= r_p[29:0];
            default: ;
        endcase
    end

    // square root of 4Q and shared divider
    logic        w_sq_busy, w_dv_busy;
    logic [31:0] w_root, w_dvs;
    logic [51:0] w_quot;

    assign w_dvs = (i_cmd.div_sel == jdd_pkg::DS_RAD) ? w_root : 32'(r_mag);

    jdd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_v     ({r_q[61:0], 2'b00}),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    jdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_p[51:0]),
        .i_divisor  (w_dvs),
        .o_busy     (w_dv_busy),
        .o_quot     (w_quot)
    );

    // magnitude: round, scale and cap
    logic [25:0] w_mag_full;
    logic [63:0] w_mag_rnd;
    assign w_mag_rnd  = r_p + (64'd1 << 37);
    assign w_mag_full = w_mag_rnd[63:38];

    // rectangular shrink per axis
    function automatic logic signed [15:0] shrink(input logic signed [15:0] v,
                                                  input logic [14:0] d);
        logic signed [16:0] sv, sd;
        logic signed [16:0] r;
        sv = 17'(v);
        sd = 17'(signed'({1'b0, d}));
        if (sv < -sd)     r = sv + sd;
        else if (sv > sd) r = sv - sd;
        else              r = 17'sd0;
        return r[15:0];
    endfunction

    // direction sector from held angle; /45 done by reciprocal 1457/2^16
    logic signed [23:0] w_a180;
    logic signed [23:0] w_abias;
    logic signed [8:0]  w_deg;
    logic [8:0]         w_n;
    logic [19:0]        w_nq;
    logic [3:0]         w_sec;
    assign w_a180  = 24'(signed'(r_hangle)) * 24'sd180;
    assign w_abias = w_a180[23] ? w_a180 + 24'sd32767 : w_a180;
    assign w_deg   = 9'(w_abias >>> 15);
    assign w_n     = 9'(10'sd202 + 10'(w_deg));
    assign w_nq    = 20'(w_n) * 20'd1457;
    assign w_sec   = (w_nq[19:16] + 4'd1 > 4'd8) ? 4'd1 : w_nq[19:16] + 4'd1;

    // net force and projections
    logic [15:0] w_q16;
    assign w_q16 = w_quot[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hangle <= 16'd0;
            r_hdir   <= 4'd0;
        end else begin
            if (i_cmd.cap_mag && r_nz) begin
                r_hangle <= 16'((r_z + 32'h0000_8000) >> 16);
            end
            if (i_cmd.cap_dir && r_nz) begin
                r_hdir <= w_sec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_mag) begin
            r_mag <= !r_nz ? 20'd0 :
                     (w_mag_full > 26'(jdd_pkg::MAG_MAX)) ? jdd_pkg::MAG_MAX :
                     w_mag_full[19:0];
            r_net <= 20'd0;
            r_xo  <= r_rect ? shrink(r_x, r_dead_x) : 16'sd0;
            r_yo  <= r_rect ? shrink(r_y, r_dead_y) : 16'sd0;
        end
        if (i_cmd.cap_net) begin
            r_net <= (52'(r_mag) > w_quot) ? r_mag - w_quot[19:0] : 20'd0;
        end
        if (i_cmd.cap_xo) begin
            r_xo <= r_x[15] ? -signed'(w_q16) : signed'(w_q16);
        end
        if (i_cmd.cap_yo) begin
            r_yo <= r_y[15] ? -signed'(w_q16) : signed'(w_q16);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_m_tdata <= {4'd0, r_hangle, r_net, r_mag, r_hdir, r_yo, r_xo};
        end
    end

    assign o_stat.nz        = r_nz;
    assign o_stat.rect      = r_rect;
    assign o_stat.sqrt_busy = w_sq_busy;
    assign o_stat.div_busy  = w_dv_busy;
endmodule

// ----- hdl/jdd_ctrl.sv -----
// Controller: sequences CORDIC, multiplies, sqrt and divides; owns handshakes.
// Uses jdd_pkg.
module jdd_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  jdd_pkg::t_stat i_stat,
    output jdd_pkg::t_cmd  o_cmd
);
    localparam int CW = $clog2(CORDIC_STEPS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_COR  = 5'd1;
    localparam logic [4:0] S_MMUL = 5'd2;
    localparam logic [4:0] S_MAG  = 5'd3;
    localparam logic [4:0] S_DIR  = 5'd4;
    localparam logic [4:0] S_AA   = 5'd5;
    localparam logic [4:0] S_YY   = 5'd6;
    localparam logic [4:0] S_W1   = 5'd7;
    localparam logic [4:0] S_T1   = 5'd8;
    localparam logic [4:0] S_BB   = 5'd9;
    localparam logic [4:0] S_XX   = 5'd10;
    localparam logic [4:0] S_W2   = 5'd11;
    localparam logic [4:0] S_T2   = 5'd12;
    localparam logic [4:0] S_AB   = 5'd13;
    localparam logic [4:0] S_SQ   = 5'd14;
    localparam logic [4:0] S_SQW  = 5'd15;
    localparam logic [4:0] S_RM   = 5'd16;
    localparam logic [4:0] S_RD   = 5'd17;
    localparam logic [4:0] S_RDW  = 5'd18;
    localparam logic [4:0] S_NET  = 5'd19;
    localparam logic [4:0] S_PXM  = 5'd20;
    localparam logic [4:0] S_PXD  = 5'd21;
    localparam logic [4:0] S_PXW  = 5'd22;
    localparam logic [4:0] S_PYM  = 5'd23;
    localparam logic [4:0] S_PYD  = 5'd24;
    localparam logic [4:0] S_PYW  = 5'd25;
    localparam logic [4:0] S_PYC  = 5'd26;
    localparam logic [4:0] S_FIN  = 5'd27;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    logic          w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;
    assign w_out_free = !r_valid || i_m_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = (r_valid && i_m_tready) ? 1'b0 : r_valid;
        o_cmd   = '0;
        o_cmd.step = jdd_pkg::STEP_W'(r_cnt);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_COR;
                end
            end
            S_COR: begin
                o_cmd.cor_en = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CW'(CORDIC_STEPS - 1)) n_state = S_MMUL;
            end
            S_MMUL: begin o_cmd.mul_sel = jdd_pkg::MS_CK; n_state = S_MAG; end
            S_MAG:  begin o_cmd.cap_mag = 1'b1; n_state = S_DIR; end
            S_DIR: begin
                o_cmd.cap_dir = 1'b1;
                n_state = (i_stat.rect || !i_stat.nz) ? S_FIN : S_AA;
            end
            S_AA: begin o_cmd.mul_sel = jdd_pkg::MS_AA; n_state = S_YY; end
            S_YY: begin
                o_cmd.mul_sel = jdd_pkg::MS_YY;
                o_cmd.cap_sel = jdd_pkg::CP_TA;
                n_state = S_W1;
            end
            S_W1: begin o_cmd.cap_sel = jdd_pkg::CP_TB; n_state = S_T1; end
            S_T1: begin o_cmd.mul_sel = jdd_pkg::MS_T; n_state = S_BB; end
            S_BB: begin
                o_cmd.mul_sel = jdd_pkg::MS_BB;
                o_cmd.cap_sel = jdd_pkg::CP_Q;
                n_state = S_XX;
            end
            S_XX: begin
                o_cmd.mul_sel = jdd_pkg::MS_XX;
                o_cmd.cap_sel = jdd_pkg::CP_TA;
                n_state = S_W2;
            end
            S_W2: begin o_cmd.cap_sel = jdd_pkg::CP_TB; n_state = S_T2; end
            S_T2: begin o_cmd.mul_sel = jdd_pkg::MS_T; n_state = S_AB; end
            S_AB: begin
                o_cmd.mul_sel = jdd_pkg::MS_AB;
                o_cmd.cap_sel = jdd_pkg::CP_QADD;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.cap_sel    = jdd_pkg::CP_AB;
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQW;
            end
            S_SQW: if (!i_stat.sqrt_busy) n_state = S_RM;
            S_RM:  begin o_cmd.mul_sel = jdd_pkg::MS_RM; n_state = S_RD; end
            S_RD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = jdd_pkg::DS_RAD;
                n_state = S_RDW;
            end
            S_RDW: if (!i_stat.div_busy) n_state = S_NET;
            S_NET: begin o_cmd.cap_net = 1'b1; n_state = S_PXM; end
            S_PXM: begin o_cmd.mul_sel = jdd_pkg::MS_PX; n_state = S_PXD; end
            S_PXD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = jdd_pkg::DS_PRJ;
                n_state = S_PXW;
            end
            S_PXW: if (!i_stat.div_busy) n_state = S_PYM;
            S_PYM: begin
                o_cmd.cap_xo  = 1'b1;
                o_cmd.mul_sel = jdd_pkg::MS_PY;
                n_state = S_PYD;
            end
            S_PYD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = jdd_pkg::DS_PRJ;
                n_state = S_PYW;
            end
            S_PYW: if (!i_stat.div_busy) n_state = S_PYC;
            S_PYC: begin o_cmd.cap_yo = 1'b1; n_state = S_FIN; end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end
endmodule
